// ----- rtl/core/itp_pkg.sv -----
// itp_pkg: token and result codes, operator precedence and the command and
// status structs shared by the controller and datapath of the converter.
// No dependencies.
package itp_pkg;

  // input token kinds
  localparam logic [1:0] TOK_OPERAND = 2'd0;
  localparam logic [1:0] TOK_OPERATOR = 2'd1;
  localparam logic [1:0] TOK_OPEN = 2'd2;
  localparam logic [1:0] TOK_CLOSE = 2'd3;

  // result kinds
  localparam logic [1:0] RES_OPERAND = 2'd0;
  localparam logic [1:0] RES_OPERATOR = 2'd1;
  localparam logic [1:0] RES_END = 2'd2;
  localparam logic [1:0] RES_ERROR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED_CLOSE = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED_OPEN = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // operator codes
  localparam logic [3:0] OP_OR = 4'd0;
  localparam logic [3:0] OP_AND = 4'd1;
  localparam logic [3:0] OP_EQ = 4'd2;
  localparam logic [3:0] OP_NE = 4'd3;
  localparam logic [3:0] OP_LT = 4'd4;
  localparam logic [3:0] OP_GT = 4'd5;
  localparam logic [3:0] OP_LE = 4'd6;
  localparam logic [3:0] OP_GE = 4'd7;
  localparam logic [3:0] OP_ADD = 4'd8;
  localparam logic [3:0] OP_SUB = 4'd9;
  localparam logic [3:0] OP_MUL = 4'd10;
  localparam logic [3:0] OP_DIV = 4'd11;
  localparam logic [3:0] OP_POW = 4'd12;

  // stack entry for an open parenthesis
  localparam logic [3:0] PAREN_MARK = 4'd15;

  function automatic logic [2:0] op_prec(input logic [3:0] code);
    logic [2:0] p;
    case (code)
      OP_OR: p = 3'd1;
      OP_AND: p = 3'd2;
      OP_EQ, OP_NE: p = 3'd3;
      OP_LT, OP_GT, OP_LE, OP_GE: p = 3'd4;
      OP_ADD, OP_SUB: p = 3'd5;
      OP_MUL, OP_DIV: p = 3'd6;
      OP_POW: p = 3'd7;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_err;
    logic       rel;
    logic       rel_eoe;
    logic       end_mark;
    logic       push;
    logic       push_paren;
    logic       pop;
    logic       clear;
    logic       set_disc;
    logic       clr_disc;
  } itp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       code_ok;
    logic       last;
    logic       disc;
    logic       fill_zero;
    logic       full;
    logic       top_paren;
    logic       pop_ok;
    logic       hold_valid;
    logic       out_free;
    logic       emitted;
  } itp_sts_t;

endpackage

// ----- rtl/core/itp_ram.sv -----
// itp_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/itp_datapath.sv -----
// itp_datapath: token latch, operator stack with fill count and top bypass,
// hold register and output register. Depends on itp_pkg and itp_ram.
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  itp_cmd_t    cmd,
  output itp_sts_t    sts,
  input  logic [1:0]  in_token_kind,
  input  logic [3:0]  in_operator_code,
  input  logic [31:0] in_operand_handle,
  input  logic        in_last_token,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_operator,
  output logic [31:0] out_operand,
  output logic [1:0]  out_error_code,
  output logic        out_end_of_expression
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  // latched token
  logic [1:0]  tok_kind_r, tok_kind_nxt;
  logic [3:0]  tok_code_r, tok_code_nxt;
  logic [31:0] tok_handle_r, tok_handle_nxt;
  logic        tok_last_r, tok_last_nxt;

  // stack control
  logic [FW-1:0] fill_r, fill_nxt;
  logic          disc_r, disc_nxt;
  logic          emitted_r, emitted_nxt;
  logic          byp_valid_r, byp_valid_nxt;
  logic [3:0]    byp_r, byp_nxt;
  logic [3:0]    wr_data;
  logic [AW-1:0] rd_idx;
  logic [3:0]    rd_data;
  logic [3:0]    top;
  logic [2:0]    p_in, p_top;

  // hold and output registers
  logic        hold_valid_r, hold_valid_nxt;
  logic [1:0]  hold_kind_r, hold_kind_nxt;
  logic [3:0]  hold_op_r, hold_op_nxt;
  logic [31:0] hold_opnd_r, hold_opnd_nxt;
  logic [1:0]  hold_err_r, hold_err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_op_r, out_op_nxt;
  logic [31:0] out_opnd_r, out_opnd_nxt;
  logic [1:0]  out_err_r, out_err_nxt;
  logic        out_eoe_r, out_eoe_nxt;
  logic        out_free;
  logic        move;

  assign wr_data = cmd.push_paren ? PAREN_MARK : tok_code_r;

  itp_ram #(
    .WIDTH (4),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (fill_r[AW-1:0]),
    .wdata (wr_data),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // a freshly pushed entry is not yet visible through the registered read
  assign top = byp_valid_r ? byp_r : rd_data;
  assign p_in = op_prec(tok_code_r);
  assign p_top = op_prec(top);
  assign out_free = !out_valid_r || !out_stall;
  assign move = (cmd.emit && hold_valid_r) || cmd.rel;

  always_comb begin
    tok_kind_nxt = tok_kind_r;
    tok_code_nxt = tok_code_r;
    tok_handle_nxt = tok_handle_r;
    tok_last_nxt = tok_last_r;
    if (cmd.accept) begin
      tok_kind_nxt = in_token_kind;
      tok_code_nxt = in_operator_code;
      tok_handle_nxt = in_operand_handle;
      tok_last_nxt = in_last_token;
    end

    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - FW'(1);
    end
    // read address follows the next fill so the top is ready every cycle
    if (fill_nxt == '0) begin
      rd_idx = '0;
    end else begin
      rd_idx = AW'(fill_nxt - FW'(1));
    end
    byp_valid_nxt = cmd.push;
    byp_nxt = cmd.push ? wr_data : byp_r;

    disc_nxt = disc_r;
    if (cmd.set_disc) begin
      disc_nxt = 1'b1;
    end else if (cmd.clr_disc) begin
      disc_nxt = 1'b0;
    end
    emitted_nxt = emitted_r;
    if (cmd.accept) begin
      emitted_nxt = 1'b0;
    end else if (cmd.emit) begin
      emitted_nxt = 1'b1;
    end

    hold_valid_nxt = hold_valid_r;
    hold_kind_nxt = hold_kind_r;
    hold_op_nxt = hold_op_r;
    hold_opnd_nxt = hold_opnd_r;
    hold_err_nxt = hold_err_r;
    if (cmd.emit) begin
      hold_valid_nxt = 1'b1;
      hold_kind_nxt = cmd.emit_kind;
      hold_op_nxt = (cmd.emit_kind == RES_OPERATOR) ? top : 4'd0;
      hold_opnd_nxt = (cmd.emit_kind == RES_OPERAND) ? tok_handle_r : 32'd0;
      hold_err_nxt = cmd.emit_err;
    end else if (cmd.rel) begin
      hold_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_op_nxt = out_op_r;
    out_opnd_nxt = out_opnd_r;
    out_err_nxt = out_err_r;
    out_eoe_nxt = out_eoe_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt = hold_kind_r;
      out_op_nxt = hold_op_r;
      out_opnd_nxt = hold_opnd_r;
      out_err_nxt = hold_err_r;
      out_eoe_nxt = cmd.rel && cmd.rel_eoe;
    end else if (cmd.end_mark) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt = RES_END;
      out_op_nxt = 4'd0;
      out_opnd_nxt = 32'd0;
      out_err_nxt = ERR_NONE;
      out_eoe_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      disc_r <= 1'b0;
      emitted_r <= 1'b0;
      byp_valid_r <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      disc_r <= disc_nxt;
      emitted_r <= emitted_nxt;
      byp_valid_r <= byp_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_kind_r <= tok_kind_nxt;
    tok_code_r <= tok_code_nxt;
    tok_handle_r <= tok_handle_nxt;
    tok_last_r <= tok_last_nxt;
    byp_r <= byp_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_op_r <= hold_op_nxt;
    hold_opnd_r <= hold_opnd_nxt;
    hold_err_r <= hold_err_nxt;
    out_kind_r <= out_kind_nxt;
    out_op_r <= out_op_nxt;
    out_opnd_r <= out_opnd_nxt;
    out_err_r <= out_err_nxt;
    out_eoe_r <= out_eoe_nxt;
  end

  always_comb begin
    sts.kind = tok_kind_r;
    sts.code_ok = (tok_code_r <= OP_POW);
    sts.last = tok_last_r;
    sts.disc = disc_r;
    sts.fill_zero = (fill_r == '0);
    sts.full = (fill_r == FW'(STACK_DEPTH));
    sts.top_paren = (top == PAREN_MARK);
    // pop while the top binds at least as tightly; pow only strictly tighter
    sts.pop_ok = (fill_r != '0) && (top != PAREN_MARK) &&
                 ((p_top > p_in) || ((p_top == p_in) && (tok_code_r != OP_POW)));
    sts.hold_valid = hold_valid_r;
    sts.out_free = out_free;
    sts.emitted = emitted_r;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_operator = out_op_r;
  assign out_operand = out_opnd_r;
  assign out_error_code = out_err_r;
  assign out_end_of_expression = out_eoe_r;

endmodule

// ----- rtl/core/itp_ctrl.sv -----
// itp_ctrl: sequencing state machine of the converter; issues stack and
// result commands from the datapath status. Depends on itp_pkg.
module itp_ctrl
  import itp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  itp_sts_t sts,
  output itp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_OPPOP = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_ERR = 3'd5;
  localparam logic [2:0] S_FIN = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] err_r, err_nxt;
  logic       emit_ok;
  logic [2:0] after_tok;

  // a new result may enter the hold stage once its old content can move on
  assign emit_ok = !sts.hold_valid || sts.out_free;
  assign after_tok = sts.last ? S_FLUSH : S_IDLE;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    err_nxt = err_r;
    case (state_r)
      S_IDLE: begin
        cmd.rel = sts.hold_valid && sts.out_free;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.disc) begin
          state_nxt = sts.last ? S_FIN : S_IDLE;
        end else begin
          case (sts.kind)
            TOK_OPERAND: begin
              if (emit_ok) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = RES_OPERAND;
                state_nxt = after_tok;
              end
            end
            TOK_OPERATOR: begin
              state_nxt = sts.code_ok ? S_OPPOP : after_tok;
            end
            TOK_OPEN: begin
              if (sts.full) begin
                err_nxt = ERR_OVERFLOW;
                state_nxt = S_ERR;
              end else begin
                cmd.push = 1'b1;
                cmd.push_paren = 1'b1;
                state_nxt = after_tok;
              end
            end
            default: begin
              state_nxt = S_CLOSE;
            end
          endcase
        end
      end
      S_OPPOP: begin
        if (sts.pop_ok) begin
          if (emit_ok) begin
            cmd.emit = 1'b1;
            cmd.emit_kind = RES_OPERATOR;
            cmd.pop = 1'b1;
          end
        end else if (sts.full) begin
          err_nxt = ERR_OVERFLOW;
          state_nxt = S_ERR;
        end else begin
          cmd.push = 1'b1;
          state_nxt = after_tok;
        end
      end
      S_CLOSE: begin
        if (sts.fill_zero) begin
          err_nxt = ERR_UNMATCHED_CLOSE;
          state_nxt = S_ERR;
        end else if (sts.top_paren) begin
          cmd.pop = 1'b1;
          state_nxt = after_tok;
        end else if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = RES_OPERATOR;
          cmd.pop = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.fill_zero) begin
          state_nxt = S_FIN;
        end else if (sts.top_paren) begin
          err_nxt = ERR_UNMATCHED_OPEN;
          state_nxt = S_ERR;
        end else if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = RES_OPERATOR;
          cmd.pop = 1'b1;
        end
      end
      S_ERR: begin
        if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = RES_ERROR;
          cmd.emit_err = err_r;
          cmd.clear = 1'b1;
          if (sts.last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.set_disc = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        // the last result of this token takes the end flag; with none, a marker
        if (sts.out_free) begin
          if (sts.emitted) begin
            cmd.rel = 1'b1;
            cmd.rel_eoe = 1'b1;
            cmd.clear = 1'b1;
            cmd.clr_disc = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.hold_valid) begin
            cmd.rel = 1'b1;
          end else begin
            cmd.end_mark = 1'b1;
            cmd.clear = 1'b1;
            cmd.clr_disc = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r <= ERR_NONE;
    end else begin
      state_r <= state_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// ----- rtl/core/infix_to_postfix_converter_unit.sv -----
// infix_to_postfix_converter_unit: top level of the shunting-yard converter.
// Depends on itp_pkg, itp_ctrl, itp_datapath (and through it itp_ram).
//
//   channel  direction  handshake          payload
//   in_      request in   in_valid/in_stall    token kind, operator, handle, last
//   out_     request out  out_valid/out_stall  kind, operator, operand, error, end
//
// A request is first taken and then processed, and the converter takes no new
// request until it is back in idle; operator and close requests add a stack step,
// and every operator popped adds a step. The last request of an expression adds
// an empty-stack check and the end flag (a dropped one only the end flag), plus
// a release step while an earlier result still sits in the hold stage; an error
// result adds a step.
// Stack pops are bound by the single-read stack RAM.
// Reset clears the fill count, so the stack needs no clearing pass.
// A held output stalls only the steps that produce a further result.
module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_token_kind,
  input  logic [3:0]  in_operator_code,
  input  logic [31:0] in_operand_handle,
  input  logic        in_last_token,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_operator,
  output logic [31:0] out_operand,
  output logic [1:0]  out_error_code,
  output logic        out_end_of_expression
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_token_kind         (in_token_kind),
    .in_operator_code      (in_operator_code),
    .in_operand_handle     (in_operand_handle),
    .in_last_token         (in_last_token),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_operator          (out_operator),
    .out_operand           (out_operand),
    .out_error_code        (out_error_code),
    .out_end_of_expression (out_end_of_expression)
  );

endmodule

// ----- dv/postfix_checker.sv -----
`timescale 1ns / 100ps
// postfix_checker: watches the token and result channels of the converter,
// keeps its own operator stack to predict the postfix stream, and compares
// every result field by field. Depends on itp_pkg for the token and result codes.
module postfix_checker
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_token_kind,
  input  logic [3:0]  in_operator_code,
  input  logic [31:0] in_operand_handle,
  input  logic        in_last_token,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [3:0]  out_operator,
  input  logic [31:0] out_operand,
  input  logic [1:0]  out_error_code,
  input  logic        out_end_of_expression,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [31:0] operand;
    logic [1:0]  err;
    logic        eoe;
  } postfix_item_t;

  postfix_item_t postfix_expected[$];
  postfix_item_t want;
  logic [3:0]    op_stack[STACK_DEPTH];
  int            held_ops = 0;
  bit            dropping = 1'b0;
  int            step_results;
  int            fail_count = 0;

  function automatic int op_rank(input logic [3:0] code);
    if (code == OP_POW) return 7;
    else if (code >= OP_MUL) return 6;
    else if (code >= OP_ADD) return 5;
    else if (code >= OP_LT) return 4;
    else if (code >= OP_EQ) return 3;
    else return code + 1;
  endfunction

  task automatic put_item(input logic [1:0] kind, input logic [3:0] op,
                          input logic [31:0] operand, input logic [1:0] err);
    postfix_item_t item;
    item.kind = kind;
    item.op = op;
    item.operand = operand;
    item.err = err;
    item.eoe = 1'b0;
    postfix_expected.insert(postfix_expected.size(), item);
    step_results++;
  endtask

  task automatic convert_token(input logic [1:0] kind, input logic [3:0] code,
                               input logic [31:0] handle, input logic last);
    logic [1:0]    fault;
    logic [3:0]    top;
    bit            done;
    step_results = 0;
    fault = ERR_NONE;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        held_ops = 0;
        put_item(RES_END, 4'd0, 32'd0, ERR_NONE);
        postfix_expected[postfix_expected.size() - 1].eoe = 1'b1;
      end
      return;
    end

    case (kind)
      TOK_OPERAND: begin
        put_item(RES_OPERAND, 4'd0, handle, ERR_NONE);
      end
      TOK_OPERATOR: begin
        // codes past pow are ignored outright
        if (code <= OP_POW) begin
          done = 1'b0;
          while (held_ops > 0 && !done) begin
            top = op_stack[held_ops-1];
            if (top != PAREN_MARK && (op_rank(top) > op_rank(code) ||
                (op_rank(top) == op_rank(code) && code != OP_POW))) begin
              put_item(RES_OPERATOR, top, 32'd0, ERR_NONE);
              held_ops--;
            end else begin
              done = 1'b1;
            end
          end
          if (held_ops >= STACK_DEPTH) begin
            fault = ERR_OVERFLOW;
          end else begin
            op_stack[held_ops] = code;
            held_ops++;
          end
        end
      end
      TOK_OPEN: begin
        if (held_ops >= STACK_DEPTH) begin
          fault = ERR_OVERFLOW;
        end else begin
          op_stack[held_ops] = PAREN_MARK;
          held_ops++;
        end
      end
      default: begin
        done = 1'b0;
        while (!done) begin
          if (held_ops == 0) begin
            fault = ERR_UNMATCHED_CLOSE;
            done = 1'b1;
          end else begin
            top = op_stack[held_ops-1];
            held_ops--;
            if (top == PAREN_MARK) done = 1'b1;
            else put_item(RES_OPERATOR, top, 32'd0, ERR_NONE);
          end
        end
      end
    endcase

    // end of expression empties the stack, stopping at a stray open
    if (fault == ERR_NONE && last) begin
      done = 1'b0;
      while (held_ops > 0 && !done) begin
        top = op_stack[held_ops-1];
        if (top == PAREN_MARK) begin
          fault = ERR_UNMATCHED_OPEN;
          done = 1'b1;
        end else begin
          put_item(RES_OPERATOR, top, 32'd0, ERR_NONE);
          held_ops--;
        end
      end
    end

    if (fault != ERR_NONE) begin
      put_item(RES_ERROR, 4'd0, 32'd0, fault);
      held_ops = 0;
      if (!last) dropping = 1'b1;
    end

    if (last) begin
      if (step_results == 0) put_item(RES_END, 4'd0, 32'd0, ERR_NONE);
      postfix_expected[postfix_expected.size() - 1].eoe = 1'b1;
      held_ops = 0;
      dropping = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_ops = 0;
      dropping = 1'b0;
      postfix_expected.delete();
    end else begin
      if (in_valid && !in_stall) begin
        convert_token(in_token_kind, in_operator_code, in_operand_handle, in_last_token);
      end
      if (out_valid && !out_stall) begin
        if (postfix_expected.size() == 0) begin
          $error("result with nothing expected: kind %0d operator %0d operand %h",
                 out_kind, out_operator, out_operand);
          fail_count++;
        end else begin
          want = postfix_expected.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_operator !== want.op) begin
            $error("out_operator: expected %0d, got %0d", want.op, out_operator);
            fail_count++;
          end
          if (out_operand !== want.operand) begin
            $error("out_operand: expected %h, got %h", want.operand, out_operand);
            fail_count++;
          end
          if (out_error_code !== want.err) begin
            $error("out_error_code: expected %0d, got %0d", want.err, out_error_code);
            fail_count++;
          end
          if (out_end_of_expression !== want.eoe) begin
            $error("out_end_of_expression: expected %0d, got %0d",
                   want.eoe, out_end_of_expression);
            fail_count++;
          end
        end
      end
    end
    failures <= fail_count;
    pending <= postfix_expected.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: drives infix token requests into the converter under changing idle
// patterns and gives the verdict. Depends on itp_pkg, postfix_checker and
// infix_to_postfix_converter_unit.
module testbench;
  import itp_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_TOKENS = 210;
  localparam int LONG_HOLD = 400;
  localparam logic [3:0] OP_CODE_BAD = 4'd13;
  localparam logic [3:0] OP_CODE_TOP = 4'd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [31:0] handle;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_token_kind;
  logic [3:0]  in_operator_code;
  logic [31:0] in_operand_handle;
  logic        in_last_token;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [3:0]  out_operator;
  logic [31:0] out_operand;
  logic [1:0]  out_error_code;
  logic        out_end_of_expression;
  int          failures;
  int          pending;

  token_t expr_q[$];
  int     send_idle_pct = 32;
  int     recv_idle_pct = 81;
  int     hold_requests = 0;
  int     rnd_sent = 0;

  infix_to_postfix_converter_unit #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_token_kind(in_token_kind), .in_operator_code(in_operator_code),
    .in_operand_handle(in_operand_handle), .in_last_token(in_last_token),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_operator(out_operator), .out_operand(out_operand),
    .out_error_code(out_error_code), .out_end_of_expression(out_end_of_expression)
  );

  postfix_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_token_kind(in_token_kind), .in_operator_code(in_operator_code),
    .in_operand_handle(in_operand_handle), .in_last_token(in_last_token),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_operator(out_operator), .out_operand(out_operand),
    .out_error_code(out_error_code), .out_end_of_expression(out_end_of_expression),
    .failures(failures), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stall, or a long hold-off when the stimulus asks for one
  initial begin : result_sink
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic token_t rand_token(input logic [1:0] kind);
    token_t t;
    t.kind = kind;
    t.code = 4'($urandom_range(15));
    t.handle = $urandom;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_t tok(input logic [1:0] kind, input logic [3:0] code,
                                 input logic [31:0] handle, input logic last);
    token_t t;
    t.kind = kind;
    t.code = code;
    t.handle = handle;
    t.last = last;
    return t;
  endfunction

  task automatic offer_token(input token_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_token_kind <= t.kind;
    in_operator_code <= t.code;
    in_operand_handle <= t.handle;
    in_last_token <= t.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // well-formed infix with random operands, operators and nesting
  task automatic build_expression(input int terms_wanted, input int max_nest,
                                  input int open_pct, input int pow_pct);
    int     nest;
    int     terms;
    bit     want_operand;
    bit     done;
    token_t t;
    expr_q.delete();
    nest = 0;
    terms = 0;
    want_operand = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (want_operand) begin
        if (nest < max_nest && $urandom_range(99) < open_pct) begin
          expr_q.insert(expr_q.size(), rand_token(TOK_OPEN));
          nest++;
        end else begin
          expr_q.insert(expr_q.size(), rand_token(TOK_OPERAND));
          want_operand = 1'b0;
          terms++;
        end
      end else if (nest > 0 && (terms >= terms_wanted || $urandom_range(99) < 35)) begin
        expr_q.insert(expr_q.size(), rand_token(TOK_CLOSE));
        nest--;
      end else if (terms >= terms_wanted) begin
        done = 1'b1;
      end else begin
        t = rand_token(TOK_OPERATOR);
        if ($urandom_range(99) < pow_pct) t.code = OP_POW;
        else t.code = 4'($urandom_range(OP_POW));
        expr_q.insert(expr_q.size(), t);
        want_operand = 1'b1;
      end
    end
  endtask

  task automatic send_expression();
    expr_q[expr_q.size() - 1].last = 1'b1;
    foreach (expr_q[i]) offer_token(expr_q[i]);
    rnd_sent += expr_q.size();
  endtask

  initial begin : stimulus
    int     phase;
    int     pick;
    token_t t;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_token_kind <= TOK_OPERAND;
    in_operator_code <= OP_OR;
    in_operand_handle <= 32'd0;
    in_last_token <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // rising precedence fills the stack, the pow chain overflows it
    offer_token(tok(TOK_OPERATOR, OP_OR, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_AND, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_EQ, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_LT, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_ADD, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_MUL, $urandom, 1'b0));
    repeat (11) offer_token(tok(TOK_OPERATOR, OP_POW, $urandom, 1'b0));
    // dropped token ends the expression with an empty marker
    offer_token(tok(TOK_OPERAND, OP_CODE_TOP, 32'd0, 1'b1));
    // equal precedence pops, bad codes ignored, last on a bad code still flushes
    offer_token(tok(TOK_OPERATOR, OP_NE, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_GT, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_LE, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_GE, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_SUB, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_DIV, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_CODE_BAD, $urandom, 1'b0));
    offer_token(tok(TOK_OPERATOR, OP_CODE_TOP, $urandom, 1'b1));
    // unmatched close after a pending operator
    offer_token(tok(TOK_OPERATOR, OP_ADD, $urandom, 1'b0));
    offer_token(tok(TOK_CLOSE, OP_OR, 32'hFFFF_FFFF, 1'b1));
    // unmatched open found by the flush
    offer_token(tok(TOK_OPEN, OP_CODE_TOP, 32'd0, 1'b0));
    offer_token(tok(TOK_OPERAND, OP_OR, 32'hFFFF_FFFF, 1'b1));

    phase = 1;
    while (rnd_sent < RANDOM_TOKENS) begin
      if (phase == 1 && rnd_sent >= RANDOM_TOKENS / 3) begin
        await_drain();
        phase = 2;
        send_idle_pct = 81;
        recv_idle_pct <= 32;
      end else if (phase == 2 && rnd_sent >= 2 * RANDOM_TOKENS / 3) begin
        await_drain();
        phase = 3;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
      end
      pick = $urandom_range(99);
      if (pick < 68) begin
        build_expression($urandom_range(1, 6), 4, 30, 15);
        send_expression();
      end else if (pick < 78) begin
        // deep nesting and pow chains push towards overflow
        build_expression($urandom_range(6, 20), 20, 85, 60);
        send_expression();
      end else if (pick < 90) begin
        build_expression($urandom_range(1, 5), 3, 40, 15);
        case ($urandom_range(2))
          0: if (expr_q.size() > 1) expr_q.delete($urandom_range(expr_q.size() - 1));
          1: expr_q.insert($urandom_range(expr_q.size() - 1), rand_token(TOK_CLOSE));
          default: expr_q.insert($urandom_range(expr_q.size() - 1), rand_token(TOK_OPEN));
        endcase
        send_expression();
      end else begin
        repeat (4) begin
          t = rand_token(2'($urandom_range(3)));
          t.last = ($urandom_range(5) == 0);
          offer_token(t);
          rnd_sent++;
        end
      end
    end

    await_drain();
    repeat (40) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/itp_pkg.sv
rtl/core/itp_ram.sv
rtl/core/itp_datapath.sv
rtl/core/itp_ctrl.sv
rtl/core/infix_to_postfix_converter_unit.sv
dv/postfix_checker.sv
dv/testbench.sv
